>>> sv/rmsn_pkg.sv
// Shared types and constants for the RMS normalization block.
// Holds the controller/datapath command and status structs and the state enum.
// No dependencies.
package rmsn_pkg;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned LEN_W      = 13;
  localparam int unsigned EPS_W      = 16;
  localparam int unsigned SUM_W      = 60;
  localparam int unsigned SQ_W       = 48;
  localparam int unsigned DIV_W      = 61;
  localparam int unsigned DIV_CNT_W  = 6;
  localparam int unsigned RAD_W      = 50;
  localparam int unsigned ROOT_W     = RAD_W / 2;
  localparam int unsigned ROOT_CNT_W = 5;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned MAX_LENGTH = 4096;

  localparam logic [CFG_IDX_W-1:0] REG_VECTOR_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EPSILON       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_APPLY_GAIN    = 2'd2;

  localparam logic [LEN_W-1:0]  VLEN_RESET  = 13'd2048;
  localparam logic [EPS_W-1:0]  EPS_RESET   = 16'd1;
  localparam logic [SUM_W-1:0]  SUM_MAX     = {SUM_W{1'b1}};
  localparam logic [DATA_W-1:0] SCALE_MAX   = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] INT_MAX     = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] INT_MIN     = 32'h8000_0000;
  localparam logic [DIV_W-1:0]  INV_NUMER   = DIV_W'(1) << 48;

  localparam logic CMD_ACCUMULATE = 1'b0;
  localparam logic CMD_NORMALIZE  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ACCUM,
    ST_START_MEAN,
    ST_WAIT_MEAN,
    ST_START_INV,
    ST_WAIT_INV,
    ST_WAIT_ROOT,
    ST_MUL1,
    ST_CLAMP1,
    ST_MUL2,
    ST_EMIT
  } rmsn_state_e;

  typedef struct packed {
    logic in_en;
    logic sq_en;
    logic acc_en;
    logic clr_en;
    logic div_start;
    logic div_inv;
    logic mean_en;
    logic inv_sat_en;
    logic sqrt_start;
    logic inv_en;
    logic mul1_en;
    logic clamp1_en;
    logic mul2_en;
    logic emit_en;
  } rmsn_cmd_t;

  typedef struct packed {
    logic req_cmd;
    logic vec_done;
    logic div_done;
    logic sqrt_done;
    logic mean_zero;
    logic gain_on;
    logic out_free;
  } rmsn_stat_t;

endpackage

>>> sv/rmsn_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Shared by the mean and reciprocal divisions. Depends on rmsn_pkg.
module rmsn_div import rmsn_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [DIV_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DIV_W-1:0] quotient_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0]     rem_q, rem_d;
  logic [DIV_W-1:0]     quo_q, quo_d;
  logic [DIV_W-1:0]     dvs_q, dvs_d;
  logic [DIV_W:0]       rem_sh;
  logic [DIV_W:0]       rem_sub;
  logic                 ge;

  assign rem_sh  = {rem_q, quo_q[DIV_W-1]};
  assign ge      = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
      quo_d = {quo_q[DIV_W-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

>>> sv/rmsn_sqrt.sv
// Iterative integer square root, one root bit per cycle.
// Digit-by-digit method on bit pairs of the radicand. Depends on rmsn_pkg.
module rmsn_sqrt import rmsn_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [RAD_W-1:0]  radicand_i,
  output logic              done_o,
  output logic [ROOT_W-1:0] root_o
);

  localparam int unsigned REM_W = ROOT_W + 2;

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [ROOT_CNT_W-1:0] cnt_q, cnt_d;
  logic [RAD_W-1:0]      rad_q, rad_d;
  logic [REM_W-1:0]      rem_q, rem_d;
  logic [ROOT_W-1:0]     root_q, root_d;
  logic [REM_W+1:0]      rem_sh;
  logic [REM_W+1:0]      trial;
  logic [REM_W+1:0]      rem_sub;
  logic                  ge;

  assign rem_sh  = {rem_q, rad_q[RAD_W-1:RAD_W-2]};
  assign trial   = {2'b00, root_q, 2'b01};
  assign ge      = rem_sh >= trial;
  assign rem_sub = rem_sh - trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rad_d  = radicand_i;
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      rem_d  = ge ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
      root_d = {root_q[ROOT_W-2:0], ge};
      rad_d  = {rad_q[RAD_W-3:0], 2'b00};
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == ROOT_CNT_W'(ROOT_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

>>> sv/rmsn_dp.sv
// Datapath: square-and-accumulate, mean and reciprocal root, scaling products,
// output register. Instantiates rmsn_div and rmsn_sqrt; depends on rmsn_pkg.
module rmsn_dp import rmsn_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rmsn_cmd_t         cmd_i,
  output rmsn_stat_t        stat_o,
  input  logic [LEN_W-1:0]  vector_length_i,
  input  logic [EPS_W-1:0]  epsilon_i,
  input  logic              apply_gain_i,
  input  logic              req_cmd_i,
  input  logic [2*DATA_W-1:0] req_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DATA_W-1:0] out_data_o,
  output logic              out_sat_o
);

  localparam logic [16:0] MaxLen = 17'(MAX_LENGTH);

  logic signed [DATA_W-1:0]   elem_q, gain_q;
  logic [SQ_W-1:0]            sq_q;
  logic [SUM_W-1:0]           sum_q;
  logic [LEN_W-1:0]           count_q;
  logic [DIV_W-1:0]           mean_q;
  logic [DATA_W-1:0]          inv_q;
  logic signed [2*DATA_W-1:0] p1_q, p2_q;
  logic signed [DATA_W-1:0]   t_q;
  logic                       flag1_q;
  logic                       out_valid_q;
  logic [DATA_W-1:0]          out_data_q;
  logic                       out_sat_q;

  logic [LEN_W-1:0]           len_nz, len_eff;
  logic [DATA_W-1:0]          mag;
  logic [2*DATA_W-1:0]        sq_full;
  logic [SUM_W:0]             sum_ext;
  logic [SUM_W-1:0]           sum_sat;
  logic [LEN_W-1:0]           count_inc;
  logic                       div_start;
  logic [DIV_W-1:0]           div_dividend, div_divisor, div_quo;
  logic                       div_done;
  logic [ROOT_W-1:0]          root;
  logic                       sqrt_done;
  logic signed [2*DATA_W-1:0] s1, s2;
  logic                       ovf1, ovf2;
  logic signed [DATA_W-1:0]   t_clamp, r_clamp;

  assign len_nz  = (vector_length_i == '0) ? LEN_W'(1) : vector_length_i;
  assign len_eff = ({4'b0, len_nz} > MaxLen) ? MaxLen[LEN_W-1:0] : len_nz;

  assign mag       = elem_q[DATA_W-1] ? 32'(-elem_q) : 32'(elem_q);
  assign sq_full   = mag * mag;
  assign sum_ext   = {1'b0, sum_q} + (SUM_W + 1)'(sq_q);
  assign sum_sat   = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
  assign count_inc = count_q + 1'b1;

  assign div_start    = cmd_i.div_start;
  assign div_dividend = cmd_i.div_inv ? INV_NUMER : {1'b0, sum_q};
  assign div_divisor  = cmd_i.div_inv ? mean_q : DIV_W'(len_eff);

  rmsn_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  rmsn_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.sqrt_start),
    .radicand_i ({1'b0, div_quo[RAD_W-2:0]}),
    .done_o     (sqrt_done),
    .root_o     (root)
  );

  assign s1      = p1_q >>> 16;
  assign ovf1    = !((&s1[2*DATA_W-1:DATA_W-1]) || !(|s1[2*DATA_W-1:DATA_W-1]));
  assign t_clamp = ovf1 ? (s1[2*DATA_W-1] ? INT_MIN : INT_MAX) : s1[DATA_W-1:0];
  assign s2      = p2_q >>> 16;
  assign ovf2    = !((&s2[2*DATA_W-1:DATA_W-1]) || !(|s2[2*DATA_W-1:DATA_W-1]));
  assign r_clamp = ovf2 ? (s2[2*DATA_W-1] ? INT_MIN : INT_MAX) : s2[DATA_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_en) begin
      elem_q <= req_data_i[DATA_W-1:0];
      gain_q <= req_data_i[2*DATA_W-1:DATA_W];
    end
    if (cmd_i.sq_en) begin
      sq_q <= sq_full[2*DATA_W-1:16];
    end
    if (cmd_i.mean_en) begin
      mean_q <= div_quo + DIV_W'(epsilon_i);
    end
    if (cmd_i.mul1_en) begin
      p1_q <= elem_q * $signed(inv_q);
    end
    if (cmd_i.clamp1_en) begin
      t_q     <= t_clamp;
      flag1_q <= ovf1;
    end
    if (cmd_i.mul2_en) begin
      p2_q <= t_q * gain_q;
    end
    if (cmd_i.emit_en) begin
      out_data_q <= apply_gain_i ? r_clamp : elem_q;
      out_sat_q  <= apply_gain_i & (ovf2 | flag1_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      count_q     <= '0;
      inv_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_en) begin
        sum_q   <= '0;
        count_q <= '0;
      end else if (cmd_i.acc_en) begin
        sum_q   <= sum_sat;
        count_q <= count_inc;
      end
      if (cmd_i.inv_sat_en) begin
        inv_q <= SCALE_MAX;
      end else if (cmd_i.inv_en) begin
        inv_q <= DATA_W'(root);
      end
      if (cmd_i.emit_en) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.req_cmd   = req_cmd_i;
  assign stat_o.vec_done  = count_inc >= len_eff;
  assign stat_o.div_done  = div_done;
  assign stat_o.sqrt_done = sqrt_done;
  assign stat_o.mean_zero = mean_q == '0;
  assign stat_o.gain_on   = apply_gain_i;
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_sat_o   = out_sat_q;

endmodule

>>> sv/rmsn_ctrl.sv
// Controller state machine: sequences accumulate, root/divide and scaling steps.
// Drives the datapath by command struct only. Depends on rmsn_pkg.
module rmsn_ctrl import rmsn_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_valid_i,
  output logic       req_ready_o,
  input  rmsn_stat_t stat_i,
  output rmsn_cmd_t  cmd_o
);

  rmsn_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          if (stat_i.req_cmd == CMD_ACCUMULATE) begin
            state_d = ST_SQUARE;
          end else if (stat_i.gain_on) begin
            state_d = ST_MUL1;
          end else begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_SQUARE:     state_d = ST_ACCUM;
      ST_ACCUM:      state_d = stat_i.vec_done ? ST_START_MEAN : ST_IDLE;
      ST_START_MEAN: state_d = ST_WAIT_MEAN;
      ST_WAIT_MEAN: begin
        if (stat_i.div_done) begin
          state_d = ST_START_INV;
        end
      end
      ST_START_INV:  state_d = stat_i.mean_zero ? ST_IDLE : ST_WAIT_INV;
      ST_WAIT_INV: begin
        if (stat_i.div_done) begin
          state_d = ST_WAIT_ROOT;
        end
      end
      ST_WAIT_ROOT: begin
        if (stat_i.sqrt_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_MUL1:       state_d = ST_CLAMP1;
      ST_CLAMP1:     state_d = ST_MUL2;
      ST_MUL2:       state_d = ST_EMIT;
      ST_EMIT: begin
        if (stat_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:       state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        req_ready_o  = 1'b1;
        cmd_o.in_en  = req_valid_i;
      end
      ST_SQUARE:     cmd_o.sq_en = 1'b1;
      ST_ACCUM:      cmd_o.acc_en = 1'b1;
      ST_START_MEAN: begin
        cmd_o.div_start = 1'b1;
        cmd_o.clr_en    = 1'b1;
      end
      ST_WAIT_MEAN:  cmd_o.mean_en = stat_i.div_done;
      ST_START_INV: begin
        cmd_o.div_inv    = 1'b1;
        cmd_o.div_start  = !stat_i.mean_zero;
        cmd_o.inv_sat_en = stat_i.mean_zero;
      end
      ST_WAIT_INV:   cmd_o.sqrt_start = stat_i.div_done;
      ST_WAIT_ROOT:  cmd_o.inv_en = stat_i.sqrt_done;
      ST_MUL1:       cmd_o.mul1_en = 1'b1;
      ST_CLAMP1:     cmd_o.clamp1_en = 1'b1;
      ST_MUL2:       cmd_o.mul2_en = 1'b1;
      ST_EMIT:       cmd_o.emit_en = stat_i.out_free;
      default:       cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> sv/rms_normalize_top.sv
// Accumulate request: the element is squared, then added to the sum; the request that closes a vector
// then runs the mean divide and, unless the mean is zero, the reciprocal divide and the root.
// Normalize request: steps MUL1, CLAMP1, MUL2 and EMIT, and no new request is taken
// until the result is emitted; pass-through (gain off) goes straight to EMIT.
// A held result stalls the input until the output register frees.
// Reset (async, active low) clears sum, count and scale and loads register defaults.
module rms_normalize_top import rmsn_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [2*DATA_W-1:0]   s_axis_tdata,   // element [31:0], gain [63:32]
  input  logic                  s_axis_tuser,   // command [0]
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [DATA_W-1:0]     m_axis_tdata,   // normalized [31:0]
  output logic                  m_axis_tuser,   // saturated [0]
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [LEN_W-1:0] vector_length_q;
  logic [EPS_W-1:0] epsilon_q;
  logic             apply_gain_q;
  rmsn_cmd_t        cmd;
  rmsn_stat_t       stat;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vector_length_q <= VLEN_RESET;
      epsilon_q       <= EPS_RESET;
      apply_gain_q    <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_VECTOR_LENGTH: vector_length_q <= cfg_data_i[LEN_W-1:0];
        REG_EPSILON:       epsilon_q       <= cfg_data_i[EPS_W-1:0];
        REG_APPLY_GAIN:    apply_gain_q    <= cfg_data_i[0];
        default:           apply_gain_q    <= apply_gain_q;
      endcase
    end
  end

  rmsn_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  rmsn_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .vector_length_i (vector_length_q),
    .epsilon_i       (epsilon_q),
    .apply_gain_i    (apply_gain_q),
    .req_cmd_i       (s_axis_tuser),
    .req_data_i      (s_axis_tdata),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .out_data_o      (m_axis_tdata),
    .out_sat_o       (m_axis_tuser)
  );

`ifndef NO_ASSERTIONS
  a_busy_after_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready stayed high after a request");

  a_no_result_on_accum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_ACCUMULATE)
    |=> !$rose(m_axis_tvalid))
    else $error("result raised by an accumulate request");

  a_sat_needs_gain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> apply_gain_q)
    else $error("saturation flag set on pass-through result");
`endif

endmodule
